// ===== design/um_exec_pkg.sv =====
// Package with the shared codes, constants and control/status types of the UM execute block.
`timescale 1ns / 1ps

package um_exec_pkg;

    localparam int WORD_W       = 32;
    localparam int REG_IDX_W    = 3;
    localparam int NUM_REGS     = 8;
    localparam int OPCODE_LSB   = 28;
    localparam int LV_REG_LSB   = 25;
    localparam int LV_VALUE_W   = 25;
    localparam int FIELD_A_LSB  = 6;
    localparam int FIELD_B_LSB  = 3;
    localparam int FIELD_C_LSB  = 0;
    localparam int DIV_CNT_W    = 5;

    localparam logic [3:0]        LAST_OPCODE  = 4'd13;
    localparam logic [WORD_W-1:0] OUTPUT_LIMIT = 32'd256;
    localparam logic [WORD_W-1:0] ALL_ONES     = '1;

    // Opcodes
    localparam logic [3:0] OP_CMOV     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_STORE    = 4'd2;
    localparam logic [3:0] OP_ADD      = 4'd3;
    localparam logic [3:0] OP_MUL      = 4'd4;
    localparam logic [3:0] OP_DIV      = 4'd5;
    localparam logic [3:0] OP_NAND     = 4'd6;
    localparam logic [3:0] OP_HALT     = 4'd7;
    localparam logic [3:0] OP_MAP      = 4'd8;
    localparam logic [3:0] OP_UNMAP    = 4'd9;
    localparam logic [3:0] OP_OUTPUT   = 4'd10;
    localparam logic [3:0] OP_INPUT    = 4'd11;
    localparam logic [3:0] OP_LOADPROG = 4'd12;
    localparam logic [3:0] OP_LOADVAL  = 4'd13;

    // Item kinds
    localparam logic OPER_EXECUTE   = 1'b0;
    localparam logic OPER_WRITEBACK = 1'b1;

    // Result actions
    localparam logic [3:0] ACT_DONE     = 4'd0;
    localparam logic [3:0] ACT_HALT     = 4'd1;
    localparam logic [3:0] ACT_LOAD     = 4'd2;
    localparam logic [3:0] ACT_STORE    = 4'd3;
    localparam logic [3:0] ACT_MAP      = 4'd4;
    localparam logic [3:0] ACT_UNMAP    = 4'd5;
    localparam logic [3:0] ACT_OUTPUT   = 4'd6;
    localparam logic [3:0] ACT_INPUT    = 4'd7;
    localparam logic [3:0] ACT_LOADPROG = 4'd8;
    localparam logic [3:0] ACT_FAULT    = 4'd9;

    // Fault codes
    localparam logic [2:0] FAULT_NONE       = 3'd0;
    localparam logic [2:0] FAULT_BAD_OPCODE = 3'd1;
    localparam logic [2:0] FAULT_DIV_ZERO   = 3'd2;
    localparam logic [2:0] FAULT_UNMAP_ZERO = 3'd3;
    localparam logic [2:0] FAULT_OUT_RANGE  = 3'd4;

    typedef struct packed {
        logic accept;    // latch the item, read B and C
        logic capture;   // keep B and C, read A
        logic exec;      // register the product
        logic div_start;
        logic div_step;
        logic finish;    // write back and load the result register
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/um_exec_ctrl.sv =====
// Controller state machine of the UM execute block.
`timescale 1ns / 1ps

module um_exec_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output um_exec_pkg::cmd_t  cmd,
    input  um_exec_pkg::sts_t  sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPS  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_OPS;
                end
            end
            S_OPS:
            begin
                cmd.capture = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_to_ops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_OPS))
        else $error("accepted item did not move to operand capture");

    a_div_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !sts.div_last) |=> (state_reg == S_DIV))
        else $error("divide left before its last step");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !sts.out_free) |=> (state_reg == S_FIN))
        else $error("result dropped while output register was full");
`endif

endmodule

// ===== design/um_exec_dp.sv =====
// Datapath of the UM execute block: register file, multiplier, divider and result register.
`timescale 1ns / 1ps

module um_exec_dp
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  um_exec_pkg::cmd_t                           cmd,
    output um_exec_pkg::sts_t                           sts,
    input  logic                                        operation,
    input  logic [um_exec_pkg::WORD_W-1:0]              instruction_word,
    input  logic [um_exec_pkg::WORD_W-1:0]              return_value,
    input  logic [um_exec_pkg::REG_IDX_W-1:0]           return_register,
    input  logic                                        input_ended,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [3:0]                                  action,
    output logic [um_exec_pkg::WORD_W-1:0]              segment_id,
    output logic [um_exec_pkg::WORD_W-1:0]              word_offset,
    output logic [um_exec_pkg::WORD_W-1:0]              data_value,
    output logic [um_exec_pkg::REG_IDX_W-1:0]           dest_register,
    output logic [um_exec_pkg::WORD_W-1:0]              new_counter,
    output logic [2:0]                                  fault_code
);

    localparam int W  = um_exec_pkg::WORD_W;
    localparam int RW = um_exec_pkg::REG_IDX_W;

    // Item registers
    logic          op_reg;
    logic [W-1:0]  ir_reg;
    logic [W-1:0]  rv_reg;
    logic [RW-1:0] rr_reg;
    logic          ie_reg;

    // Register file: two registered read ports, one write port
    logic [W-1:0]  mem [um_exec_pkg::NUM_REGS];
    logic [um_exec_pkg::NUM_REGS-1:0] vld_reg;
    logic [W-1:0]  rd0_reg;
    logic [W-1:0]  rd1_reg;
    logic [RW-1:0] rd0_addr;

    logic [W-1:0]  rb_reg;
    logic [W-1:0]  rc_reg;
    logic [W-1:0]  prod_reg;
    logic [W-1:0]  prod_next;

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [um_exec_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [W:0]    div_shift;
    logic [W:0]    div_diff;

    logic [3:0]    opcode;
    logic [RW-1:0] fa;
    logic [RW-1:0] fb;
    logic [RW-1:0] fc;
    logic          rc_zero;

    logic          we;
    logic [RW-1:0] wa;
    logic [W-1:0]  wd;
    logic [3:0]    act_next;
    logic [W-1:0]  seg_next;
    logic [W-1:0]  off_next;
    logic [W-1:0]  data_next;
    logic [RW-1:0] dest_next;
    logic [W-1:0]  pc_next;
    logic [2:0]    fault_next;
    logic          out_valid_reg;

    assign opcode  = ir_reg[um_exec_pkg::OPCODE_LSB +: 4];
    assign fa      = ir_reg[um_exec_pkg::FIELD_A_LSB +: RW];
    assign fb      = ir_reg[um_exec_pkg::FIELD_B_LSB +: RW];
    assign fc      = ir_reg[um_exec_pkg::FIELD_C_LSB +: RW];
    assign rc_zero = (rc_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= operation;
            ir_reg <= instruction_word;
            rv_reg <= return_value;
            rr_reg <= return_register;
            ie_reg <= input_ended;
        end
    end

    // Port 0 reads B on accept and A on the following cycle.
    assign rd0_addr = cmd.accept ? instruction_word[um_exec_pkg::FIELD_B_LSB +: RW] : fa;

    always_ff @(posedge clk)
    begin
        if (we && cmd.finish)
        begin
            mem[wa] <= wd;
        end
        if (cmd.accept || cmd.capture)
        begin
            rd0_reg <= vld_reg[rd0_addr] ? mem[rd0_addr] : '0;
        end
        if (cmd.accept)
        begin
            rd1_reg <= vld_reg[instruction_word[um_exec_pkg::FIELD_C_LSB +: RW]] ?
                       mem[instruction_word[um_exec_pkg::FIELD_C_LSB +: RW]] : '0;
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we && cmd.finish)
        begin
            vld_reg[wa] <= 1'b1;
        end
    end

    assign prod_next = rb_reg * rc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rb_reg <= rd0_reg;
            rc_reg <= rd1_reg;
        end
        if (cmd.exec)
        begin
            prod_reg <= prod_next;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign div_shift = {rem_reg, quo_reg[W-1]};
    assign div_diff  = div_shift - {1'b0, rc_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= rb_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!div_diff[W])
            begin
                rem_reg <= div_diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_shift[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign sts.need_div = (op_reg == um_exec_pkg::OPER_EXECUTE) &&
                          (opcode == um_exec_pkg::OP_DIV) && !rc_zero;
    assign sts.div_last = (cnt_reg == {um_exec_pkg::DIV_CNT_W{1'b1}});
    assign sts.out_free = !out_valid_reg || out_ready;

    // Result and write-back selection; rd0_reg holds register A here.
    always_comb
    begin
        we         = 1'b0;
        wa         = fa;
        wd         = rb_reg;
        act_next   = um_exec_pkg::ACT_DONE;
        seg_next   = '0;
        off_next   = '0;
        data_next  = '0;
        dest_next  = '0;
        pc_next    = '0;
        fault_next = um_exec_pkg::FAULT_NONE;
        if (op_reg == um_exec_pkg::OPER_WRITEBACK)
        begin
            we = 1'b1;
            wa = rr_reg;
            wd = ie_reg ? um_exec_pkg::ALL_ONES : rv_reg;
        end
        else if (opcode > um_exec_pkg::LAST_OPCODE)
        begin
            act_next   = um_exec_pkg::ACT_FAULT;
            fault_next = um_exec_pkg::FAULT_BAD_OPCODE;
        end
        else
        begin
            case (opcode)
                um_exec_pkg::OP_CMOV:
                begin
                    we = !rc_zero;
                end
                um_exec_pkg::OP_LOAD:
                begin
                    act_next  = um_exec_pkg::ACT_LOAD;
                    seg_next  = rb_reg;
                    off_next  = rc_reg;
                    dest_next = fa;
                end
                um_exec_pkg::OP_STORE:
                begin
                    act_next  = um_exec_pkg::ACT_STORE;
                    seg_next  = rd0_reg;
                    off_next  = rb_reg;
                    data_next = rc_reg;
                end
                um_exec_pkg::OP_ADD:
                begin
                    we = 1'b1;
                    wd = rb_reg + rc_reg;
                end
                um_exec_pkg::OP_MUL:
                begin
                    we = 1'b1;
                    wd = prod_reg;
                end
                um_exec_pkg::OP_DIV:
                begin
                    if (rc_zero)
                    begin
                        act_next   = um_exec_pkg::ACT_FAULT;
                        fault_next = um_exec_pkg::FAULT_DIV_ZERO;
                    end
                    else
                    begin
                        we = 1'b1;
                        wd = quo_reg;
                    end
                end
                um_exec_pkg::OP_NAND:
                begin
                    we = 1'b1;
                    wd = ~(rb_reg & rc_reg);
                end
                um_exec_pkg::OP_HALT:
                begin
                    act_next = um_exec_pkg::ACT_HALT;
                end
                um_exec_pkg::OP_MAP:
                begin
                    act_next  = um_exec_pkg::ACT_MAP;
                    seg_next  = rc_reg;
                    dest_next = fb;
                end
                um_exec_pkg::OP_UNMAP:
                begin
                    if (rc_zero)
                    begin
                        act_next   = um_exec_pkg::ACT_FAULT;
                        fault_next = um_exec_pkg::FAULT_UNMAP_ZERO;
                    end
                    else
                    begin
                        act_next = um_exec_pkg::ACT_UNMAP;
                        seg_next = rc_reg;
                    end
                end
                um_exec_pkg::OP_OUTPUT:
                begin
                    if (rc_reg >= um_exec_pkg::OUTPUT_LIMIT)
                    begin
                        act_next   = um_exec_pkg::ACT_FAULT;
                        fault_next = um_exec_pkg::FAULT_OUT_RANGE;
                    end
                    else
                    begin
                        act_next  = um_exec_pkg::ACT_OUTPUT;
                        data_next = rc_reg;
                    end
                end
                um_exec_pkg::OP_INPUT:
                begin
                    act_next  = um_exec_pkg::ACT_INPUT;
                    dest_next = fc;
                end
                um_exec_pkg::OP_LOADPROG:
                begin
                    act_next = um_exec_pkg::ACT_LOADPROG;
                    seg_next = rb_reg;
                    pc_next  = rc_reg;
                end
                um_exec_pkg::OP_LOADVAL:
                begin
                    we = 1'b1;
                    wa = ir_reg[um_exec_pkg::LV_REG_LSB +: RW];
                    wd = {{(W - um_exec_pkg::LV_VALUE_W){1'b0}},
                          ir_reg[um_exec_pkg::LV_VALUE_W-1:0]};
                end
                default:
                begin
                    act_next   = um_exec_pkg::ACT_FAULT;
                    fault_next = um_exec_pkg::FAULT_BAD_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            action        <= act_next;
            segment_id    <= seg_next;
            word_offset   <= off_next;
            data_value    <= data_next;
            dest_register <= dest_next;
            new_counter   <= pc_next;
            fault_code    <= fault_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while full");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((action == um_exec_pkg::ACT_FAULT) ==
                           (fault_code != um_exec_pkg::FAULT_NONE)))
        else $error("fault code disagrees with action");

    a_dest_only_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dest_register != '0) |->
            (action == um_exec_pkg::ACT_LOAD || action == um_exec_pkg::ACT_MAP ||
             action == um_exec_pkg::ACT_INPUT))
        else $error("destination register set on an action with no reply");
`endif

endmodule

// ===== design/um_instruction_execute_top.sv =====
// Top level of the UM execute block: controller plus datapath.
//
// The input channel (in_valid/in_ready) carries one item: either an
// instruction word to execute or a write-back of a value returned from
// outside (a loaded word, a new segment id or an input byte, or all ones
// when input has ended). The output channel (out_valid/out_ready) returns
// exactly one result item per input item: done, halt, a request for the
// segment store or I/O, or a fault with its code.
// An item goes from acceptance through operand read and execute to a
// valid result; the input is ready again in the cycle the result appears,
// so the block takes no new item before the last one is done. Divide adds
// one step per quotient bit in the restoring divider. The register file
// has two read ports, so B and C are read on acceptance, A the cycle after.
// Reset clears the controller, the result valid flag and the register
// file's valid bits, so every register reads as zero. When the receiver
// stalls, the finished result waits in the output register while the next
// item may already be accepted and worked on; that item then holds in its
// last step until the output register is free.
`timescale 1ns / 1ps

module um_instruction_execute_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [um_exec_pkg::WORD_W-1:0]     instruction_word,
    input  logic [um_exec_pkg::WORD_W-1:0]     return_value,
    input  logic [um_exec_pkg::REG_IDX_W-1:0]  return_register,
    input  logic                               input_ended,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         action,
    output logic [um_exec_pkg::WORD_W-1:0]     segment_id,
    output logic [um_exec_pkg::WORD_W-1:0]     word_offset,
    output logic [um_exec_pkg::WORD_W-1:0]     data_value,
    output logic [um_exec_pkg::REG_IDX_W-1:0]  dest_register,
    output logic [um_exec_pkg::WORD_W-1:0]     new_counter,
    output logic [2:0]                         fault_code
);

    um_exec_pkg::cmd_t cmd;
    um_exec_pkg::sts_t sts;

    um_exec_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    um_exec_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .instruction_word (instruction_word),
        .return_value     (return_value),
        .return_register  (return_register),
        .input_ended      (input_ended),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .segment_id       (segment_id),
        .word_offset      (word_offset),
        .data_value       (data_value),
        .dest_register    (dest_register),
        .new_counter      (new_counter),
        .fault_code       (fault_code)
    );

endmodule
